// ----- hw/rtl/banker_safety_allocator_core_macros.svh -----
// ----------------------------------------------------------------------------
// banker safety allocator assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef BANKER_SAFETY_ALLOCATOR_CORE_MACROS_SVH
`define BANKER_SAFETY_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define BSA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define BSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/bsa_pkg.sv -----
// ----------------------------------------------------------------------------
// bsa_pkg
// shared types and constants of the banker safety allocator
// ----------------------------------------------------------------------------
package bsa_pkg;

    localparam int NRES          = 3;
    localparam int RES_W         = 8;
    localparam int PROC_W        = 2;
    localparam int STATUS_W      = 3;
    localparam int CFG_IDX_W     = 2;
    localparam int NUM_PROCS_DEF = 4;

    localparam logic [RES_W-1:0] TOTAL_A_RST = 8'd10;
    localparam logic [RES_W-1:0] TOTAL_B_RST = 8'd5;
    localparam logic [RES_W-1:0] TOTAL_C_RST = 8'd7;

    localparam logic CMD_CLAIM   = 1'b0;
    localparam logic CMD_REQUEST = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_C = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANT   = 3'd0,
        ST_EXCEED  = 3'd1,
        ST_NOAVAIL = 3'd2,
        ST_UNSAFE  = 3'd3,
        ST_BUSY    = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_SCAN,
        S_FIN,
        S_RES
    } t_state;

    typedef logic [NRES-1:0][RES_W-1:0] t_res_vec;

    // one process entry: maximum claim and current allocation
    typedef struct packed {
        t_res_vec claim;
        t_res_vec alloc;
    } t_entry;

endpackage

// ----- hw/rtl/bsa_entry_mem.sv -----
// ----------------------------------------------------------------------------
// bsa_entry_mem
// per-process claim/allocation memory, one write and one registered read port
// ----------------------------------------------------------------------------
module bsa_entry_mem #(
    parameter int DEPTH = bsa_pkg::NUM_PROCS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  bsa_pkg::t_entry          i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output bsa_pkg::t_entry          o_rdata
);

    bsa_pkg::t_entry  r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    bsa_pkg::t_entry  r_rdata;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    // entries never written since reset read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_rd_vld ? r_rdata : '0;

endmodule

// ----- hw/rtl/bsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// bsa_ctrl
// request sequencer: claim/request checks, greedy safety scan, result register
// ----------------------------------------------------------------------------
module bsa_ctrl #(
    parameter int NUM_PROCS = bsa_pkg::NUM_PROCS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_command,
    input  logic [bsa_pkg::PROC_W-1:0]   i_process,
    input  bsa_pkg::t_res_vec            i_amt,
    input  bsa_pkg::t_res_vec            i_total,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output bsa_pkg::t_status             o_status,
    output logic                         o_process_done,
    output bsa_pkg::t_res_vec            o_avail,
    output logic                         o_mem_we,
    output logic [$clog2(NUM_PROCS)-1:0] o_mem_waddr,
    output bsa_pkg::t_entry              o_mem_wdata,
    output logic [$clog2(NUM_PROCS)-1:0] o_mem_raddr,
    input  bsa_pkg::t_entry              i_mem_rdata
);

    localparam int IDX_W  = $clog2(NUM_PROCS);
    localparam int USED_W = $clog2(NUM_PROCS * 255 + 1);
    localparam int WORK_W = $clog2((NUM_PROCS + 1) * 255 + 1);
    localparam int CNT_W  = $clog2(NUM_PROCS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PROCS - 1);
    localparam logic [CNT_W-1:0] ALL_CNT  = CNT_W'(NUM_PROCS);

    bsa_pkg::t_state  r_state, n_state;
    logic             r_cmd, n_cmd;
    logic [bsa_pkg::PROC_W-1:0] r_proc, n_proc;
    bsa_pkg::t_res_vec r_amt, n_amt;
    logic [bsa_pkg::NRES-1:0][USED_W-1:0] r_used, n_used;
    logic [bsa_pkg::NRES-1:0][WORK_W-1:0] r_work, n_work;
    bsa_pkg::t_entry  r_cur, n_cur;
    logic             r_busy, n_busy;
    logic [NUM_PROCS-1:0] r_done, n_done;
    logic [CNT_W-1:0] r_fin, n_fin;
    logic             r_progress, n_progress;
    logic             r_issue, n_issue;
    logic [IDX_W-1:0] r_rd_idx, n_rd_idx;
    logic             r_ev_vld, n_ev_vld;
    logic [IDX_W-1:0] r_ev_idx, n_ev_idx;
    bsa_pkg::t_status r_status, n_status;
    logic             r_pdone, n_pdone;
    logic             r_out_vld, n_out_vld;
    bsa_pkg::t_status r_out_status, n_out_status;
    logic             r_out_pdone, n_out_pdone;
    bsa_pkg::t_res_vec r_out_avail, n_out_avail;

    bsa_pkg::t_res_vec av;
    bsa_pkg::t_res_vec need;
    bsa_pkg::t_entry   ev_entry;
    logic              in_range;
    logic              is_idle;
    logic              over_need;
    logic              over_avail;
    logic              over_total;
    logic              fits;
    logic              take;
    logic              complete;
    logic [IDX_W-1:0]  proc_idx;

    // availability from the running sum of allocations, saturated at zero
    always_comb begin
        for (int r = 0; r < bsa_pkg::NRES; r++) begin
            if (USED_W'(i_total[r]) > r_used[r]) begin
                av[r] = bsa_pkg::RES_W'(USED_W'(i_total[r]) - r_used[r]);
            end else begin
                av[r] = '0;
            end
        end
    end

    assign in_range = (32'(i_process) < NUM_PROCS);
    assign proc_idx = IDX_W'(r_proc);

    // checks on the looked-up entry
    always_comb begin
        is_idle    = 1'b1;
        over_need  = 1'b0;
        over_avail = 1'b0;
        over_total = 1'b0;
        for (int r = 0; r < bsa_pkg::NRES; r++) begin
            need[r] = i_mem_rdata.claim[r] - i_mem_rdata.alloc[r];
            if (i_mem_rdata.claim[r] != '0) is_idle = 1'b0;
            if (r_amt[r] > need[r]) over_need = 1'b1;
            if (r_amt[r] > av[r]) over_avail = 1'b1;
            if (r_amt[r] > i_total[r]) over_total = 1'b1;
        end
    end

    // requesting process is seen with its tentative allocation
    assign ev_entry = (r_ev_idx == proc_idx) ? r_cur : i_mem_rdata;

    always_comb begin
        fits = 1'b1;
        for (int r = 0; r < bsa_pkg::NRES; r++) begin
            if (WORK_W'(ev_entry.claim[r] - ev_entry.alloc[r]) > r_work[r]) fits = 1'b0;
        end
    end

    assign take     = r_ev_vld && !r_done[r_ev_idx] && fits;
    assign complete = r_busy && (r_cur.alloc == r_cur.claim);

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_proc       = r_proc;
        n_amt        = r_amt;
        n_used       = r_used;
        n_work       = r_work;
        n_cur        = r_cur;
        n_busy       = r_busy;
        n_done       = r_done;
        n_fin        = r_fin;
        n_progress   = r_progress;
        n_issue      = r_issue;
        n_rd_idx     = r_rd_idx;
        n_ev_vld     = 1'b0;
        n_ev_idx     = r_rd_idx;
        n_status     = r_status;
        n_pdone      = r_pdone;
        n_out_vld    = r_out_vld && !i_out_ready;
        n_out_status = r_out_status;
        n_out_pdone  = r_out_pdone;
        n_out_avail  = r_out_avail;
        o_in_ready   = 1'b0;
        o_mem_we     = 1'b0;
        o_mem_waddr  = proc_idx;
        o_mem_wdata  = r_cur;
        o_mem_raddr  = IDX_W'(i_process);

        case (r_state)
            bsa_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_cmd   = i_command;
                    n_proc  = i_process;
                    n_amt   = i_amt;
                    n_pdone = 1'b0;
                    if (!in_range) begin
                        n_status = bsa_pkg::ST_EXCEED;
                        n_state  = bsa_pkg::S_RES;
                    end else begin
                        n_state = bsa_pkg::S_LOOK;
                    end
                end
            end
            bsa_pkg::S_LOOK: begin
                if (r_cmd == bsa_pkg::CMD_CLAIM) begin
                    if (!is_idle) begin
                        n_status = bsa_pkg::ST_BUSY;
                    end else if (over_total) begin
                        n_status = bsa_pkg::ST_EXCEED;
                    end else begin
                        o_mem_we          = 1'b1;
                        o_mem_wdata.claim = r_amt;
                        o_mem_wdata.alloc = '0;
                        n_status          = bsa_pkg::ST_GRANT;
                    end
                    n_state = bsa_pkg::S_RES;
                end else if (over_need) begin
                    n_status = bsa_pkg::ST_EXCEED;
                    n_state  = bsa_pkg::S_RES;
                end else if (over_avail) begin
                    n_status = bsa_pkg::ST_NOAVAIL;
                    n_state  = bsa_pkg::S_RES;
                end else begin
                    n_cur.claim = i_mem_rdata.claim;
                    for (int r = 0; r < bsa_pkg::NRES; r++) begin
                        n_cur.alloc[r] = i_mem_rdata.alloc[r] + r_amt[r];
                        n_work[r]      = WORK_W'(av[r] - r_amt[r]);
                    end
                    n_busy     = !is_idle;
                    n_done     = '0;
                    n_fin      = '0;
                    n_progress = 1'b0;
                    n_issue    = 1'b1;
                    n_rd_idx   = '0;
                    n_state    = bsa_pkg::S_SCAN;
                end
            end
            bsa_pkg::S_SCAN: begin
                o_mem_raddr = r_rd_idx;
                n_ev_vld    = r_issue;
                if (r_issue) begin
                    if (r_rd_idx == LAST_IDX) begin
                        n_issue = 1'b0;
                    end else begin
                        n_rd_idx = r_rd_idx + 1'b1;
                    end
                end
                if (take) begin
                    for (int r = 0; r < bsa_pkg::NRES; r++) begin
                        n_work[r] = r_work[r] + WORK_W'(ev_entry.alloc[r]);
                    end
                    n_done[r_ev_idx] = 1'b1;
                    n_fin            = r_fin + 1'b1;
                    n_progress       = 1'b1;
                end
                // end of a pass over all processes
                if (r_ev_vld && r_ev_idx == LAST_IDX) begin
                    if (n_fin == ALL_CNT) begin
                        n_state = bsa_pkg::S_FIN;
                    end else if (!n_progress) begin
                        n_status = bsa_pkg::ST_UNSAFE;
                        n_state  = bsa_pkg::S_RES;
                    end else begin
                        n_progress = 1'b0;
                        n_issue    = 1'b1;
                        n_rd_idx   = '0;
                    end
                end
            end
            bsa_pkg::S_FIN: begin
                o_mem_we = 1'b1;
                n_status = bsa_pkg::ST_GRANT;
                if (complete) begin
                    o_mem_wdata = '0;
                    n_pdone     = 1'b1;
                    for (int r = 0; r < bsa_pkg::NRES; r++) begin
                        n_used[r] = r_used[r] + USED_W'(r_amt[r]) - USED_W'(r_cur.alloc[r]);
                    end
                end else begin
                    for (int r = 0; r < bsa_pkg::NRES; r++) begin
                        n_used[r] = r_used[r] + USED_W'(r_amt[r]);
                    end
                end
                n_state = bsa_pkg::S_RES;
            end
            bsa_pkg::S_RES: begin
                if (!r_out_vld || i_out_ready) begin
                    n_out_vld    = 1'b1;
                    n_out_status = r_status;
                    n_out_pdone  = r_pdone;
                    n_out_avail  = av;
                    n_state      = bsa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bsa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= bsa_pkg::S_IDLE;
            r_used     <= '0;
            r_out_vld  <= 1'b0;
            r_issue    <= 1'b0;
            r_ev_vld   <= 1'b0;
            r_done     <= '0;
            r_fin      <= '0;
            r_progress <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_used     <= n_used;
            r_out_vld  <= n_out_vld;
            r_issue    <= n_issue;
            r_ev_vld   <= n_ev_vld;
            r_done     <= n_done;
            r_fin      <= n_fin;
            r_progress <= n_progress;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_proc       <= n_proc;
        r_amt        <= n_amt;
        r_work       <= n_work;
        r_cur        <= n_cur;
        r_busy       <= n_busy;
        r_rd_idx     <= n_rd_idx;
        r_ev_idx     <= n_ev_idx;
        r_status     <= n_status;
        r_pdone      <= n_pdone;
        r_out_status <= n_out_status;
        r_out_pdone  <= n_out_pdone;
        r_out_avail  <= n_out_avail;
    end

    assign o_out_valid    = r_out_vld;
    assign o_status       = r_out_status;
    assign o_process_done = r_out_pdone;
    assign o_avail        = r_out_avail;

endmodule

// ----- hw/rtl/banker_safety_allocator_core.sv -----
// ----------------------------------------------------------------------------
// banker_safety_allocator_core
// banker's-algorithm allocator for three resource types
// ----------------------------------------------------------------------------
// Claims and requests are handled one at a time. Per-process claim and
// allocation sit in a small memory with a registered read port. An
// out-of-range process goes straight from acceptance to the result state;
// a claim, and a request rejected on need or availability, is settled in
// the lookup state. A request that reaches the safety check makes P greedy
// passes over the process memory, P from 1 to NUM_PROCS, and is granted or
// found unsafe at the end of a pass: one entry is read and tested each
// cycle. The result waits in an output register so the next request can be
// taken while it is unread; a finished request whose result cannot be loaded
// holds the block until the previous result is taken. Total registers are to
// be written by the user only while the block is idle; the block itself does
// not enforce this.
module banker_safety_allocator_core #(
    parameter int NUM_PROCS = bsa_pkg::NUM_PROCS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bsa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bsa_pkg::RES_W-1:0]       i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_command,
    input  logic [bsa_pkg::PROC_W-1:0]      i_process,
    input  logic [bsa_pkg::RES_W-1:0]       i_amt_a,
    input  logic [bsa_pkg::RES_W-1:0]       i_amt_b,
    input  logic [bsa_pkg::RES_W-1:0]       i_amt_c,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [bsa_pkg::STATUS_W-1:0]    o_status,
    output logic                            o_process_done,
    output logic [bsa_pkg::RES_W-1:0]       o_avail_a,
    output logic [bsa_pkg::RES_W-1:0]       o_avail_b,
    output logic [bsa_pkg::RES_W-1:0]       o_avail_c
);

    localparam int IDX_W = $clog2(NUM_PROCS);

    bsa_pkg::t_res_vec r_total;
    bsa_pkg::t_res_vec amt;
    bsa_pkg::t_res_vec avail;
    bsa_pkg::t_status  status;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [IDX_W-1:0]  mem_raddr;
    bsa_pkg::t_entry   mem_wdata;
    bsa_pkg::t_entry   mem_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total[0] <= bsa_pkg::TOTAL_A_RST;
            r_total[1] <= bsa_pkg::TOTAL_B_RST;
            r_total[2] <= bsa_pkg::TOTAL_C_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bsa_pkg::CFG_TOTAL_A: r_total[0] <= i_cfg_data;
                bsa_pkg::CFG_TOTAL_B: r_total[1] <= i_cfg_data;
                bsa_pkg::CFG_TOTAL_C: r_total[2] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign amt[0] = i_amt_a;
    assign amt[1] = i_amt_b;
    assign amt[2] = i_amt_c;

    bsa_ctrl #(
        .NUM_PROCS (NUM_PROCS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_process      (i_process),
        .i_amt          (amt),
        .i_total        (r_total),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (status),
        .o_process_done (o_process_done),
        .o_avail        (avail),
        .o_mem_we       (mem_we),
        .o_mem_waddr    (mem_waddr),
        .o_mem_wdata    (mem_wdata),
        .o_mem_raddr    (mem_raddr),
        .i_mem_rdata    (mem_rdata)
    );

    bsa_entry_mem #(
        .DEPTH (NUM_PROCS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_status  = status;
    assign o_avail_a = avail[0];
    assign o_avail_b = avail[1];
    assign o_avail_c = avail[2];

endmodule

// ----- hw/rtl/bsa_checker.sv -----
// ----------------------------------------------------------------------------
// bsa_checker
// port-level checks on the banker safety allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "banker_safety_allocator_core_macros.svh"

module bsa_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic [bsa_pkg::STATUS_W-1:0]    o_status,
    input logic                            o_process_done,
    input logic [bsa_pkg::RES_W-1:0]       o_avail_a,
    input logic [bsa_pkg::RES_W-1:0]       o_avail_b,
    input logic [bsa_pkg::RES_W-1:0]       o_avail_c
);

    // a result is held until taken
    `BSA_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid, "result dropped while stalled")

    // stalled result keeps its payload
    `BSA_ASSERT_NEXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_status) && $stable(o_process_done) && $stable(o_avail_a) && $stable(o_avail_b) && $stable(o_avail_c), "result changed while stalled")

    // one request at a time: acceptance closes the input until its result is formed
    `BSA_ASSERT_NEXT(a_one_at_a_time, i_in_valid && o_in_ready, !o_in_ready, "second request taken while one in flight")

    // a freed process is only reported on a grant
    `BSA_ASSERT_NOW(a_done_on_grant, o_out_valid && o_process_done, o_status == bsa_pkg::ST_GRANT, "process freed on a non-grant result")

endmodule

bind banker_safety_allocator_core bsa_checker u_bsa_checker (.*);
